// ===== rtl/mvas_pkg.sv =====
package mvas_pkg;

    localparam int WORD_BITS = 64;
    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int HALF_BITS = WORD_BITS / 2;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_SUB    = 2'd1;
    localparam logic [1:0] CMD_MUL    = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [PROD_BITS-1:0] prod_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] cmd;
        logic       last;
        word_t      val;
        word_t      r;
        prod_t      p;
    } stage_t;

    function automatic word_t reduce_once(input word_t v, input word_t q);
        return (v >= q) ? (v - q) : v;
    endfunction

endpackage

// ===== rtl/modular_vector_add_sub_mul_top.sv =====
// Modular add / subtract / scalar multiply over a stream of vector elements.
// Input channel: in_valid/in_ready with command, first_operand, second_operand
// and last_element. Output channel: out_valid/out_ready with result_value and
// last_out. One result per request, in order.
// modulus_we/modulus_wdata write the modulus (reset value 1024); write it only
// while no request is in flight.
// Throughput: one request per cycle while the output is not stalled. Path from
// accept to out_valid: the input register, two multiplier stages, the reduction
// stage, the 128-step bit-serial remainder chain (one step per stage) and the
// output register. Add and subtract results ride along the same pipeline.
// When out_ready is low, one more request finishes into a skid register, then
// the whole pipeline holds and in_ready drops until the skid drains.
// Reset clears all valid bits and loads the modulus with 1024.
module modular_vector_add_sub_mul_top (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    modulus_we,
    input  mvas_pkg::word_t         modulus_wdata,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              command,
    input  mvas_pkg::word_t         first_operand,
    input  mvas_pkg::word_t         second_operand,
    input  logic                    last_element,
    output logic                    out_valid,
    input  logic                    out_ready,
    output mvas_pkg::word_t         result_value,
    output logic                    last_out
);
    import mvas_pkg::*;

    localparam int STEPS = PROD_BITS;

    logic   en;
    word_t  q_reg;

    logic       v1_reg, v2_reg, v3_reg;
    logic [1:0] cmd1_reg, cmd2_reg, cmd3_reg;
    logic       last1_reg, last2_reg, last3_reg;
    word_t      a1_reg, b1_reg, a2_reg, sum2_reg, neg2_reg, val3_reg;
    prod_t      product;
    stage_t     s4_reg;
    stage_t     chain [0:STEPS];

    logic       ov_reg, skid_v_reg;
    word_t      od_reg, skid_d_reg;
    logic       ol_reg, skid_l_reg;
    word_t      end_val;
    stage_t     end_stage;

    assign en       = !skid_v_reg;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_reg <= word_t'(1024);
        else if (modulus_we)
            q_reg <= modulus_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
        end
        else if (en)
        begin
            v1_reg       <= in_valid;
            v2_reg       <= v1_reg;
            v3_reg       <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cmd1_reg  <= command;
            last1_reg <= last_element;
            a1_reg    <= first_operand;
            b1_reg    <= second_operand;

            cmd2_reg  <= cmd1_reg;
            last2_reg <= last1_reg;
            a2_reg    <= a1_reg;
            sum2_reg  <= a1_reg + b1_reg;
            neg2_reg  <= reduce_once(q_reg - b1_reg, q_reg);

            cmd3_reg  <= cmd2_reg;
            last3_reg <= last2_reg;
            val3_reg  <= (cmd2_reg == CMD_ADD) ? reduce_once(sum2_reg, q_reg)
                                               : (a2_reg + neg2_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_reg <= '0;
        else if (en)
        begin
            s4_reg.valid <= v3_reg;
            s4_reg.cmd   <= cmd3_reg;
            s4_reg.last  <= last3_reg;
            s4_reg.r     <= '0;
            s4_reg.p     <= product;
            unique case (cmd3_reg)
                CMD_ADD: s4_reg.val <= val3_reg;
                CMD_SUB: s4_reg.val <= reduce_once(val3_reg, q_reg);
                default: s4_reg.val <= '0;
            endcase
        end
    end

    mvas_mul u_mul (
        .clk     (clk),
        .en      (en),
        .a       (a1_reg),
        .b       (b1_reg),
        .product (product)
    );

    assign chain[0] = s4_reg;

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        mvas_rem_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .q         (q_reg),
            .stage_in  (chain[i]),
            .stage_out (chain[i+1])
        );
    end

    assign end_stage = chain[STEPS];
    assign end_val   = (end_stage.cmd == CMD_MUL) ? end_stage.r : end_stage.val;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg     <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (out_ready || !ov_reg)
        begin
            ov_reg     <= skid_v_reg || end_stage.valid;
            skid_v_reg <= 1'b0;
        end
        else if (end_stage.valid && en)
            skid_v_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (out_ready || !ov_reg)
        begin
            od_reg <= skid_v_reg ? skid_d_reg : end_val;
            ol_reg <= skid_v_reg ? skid_l_reg : end_stage.last;
        end
        else if (end_stage.valid && en)
        begin
            skid_d_reg <= end_val;
            skid_l_reg <= end_stage.last;
        end
    end

    assign out_valid    = ov_reg;
    assign result_value = od_reg;
    assign last_out     = ol_reg;

endmodule

// ===== rtl/mvas_mul.sv =====
module mvas_mul (
    input  logic            clk,
    input  logic            en,
    input  mvas_pkg::word_t a,
    input  mvas_pkg::word_t b,
    output mvas_pkg::prod_t product
);
    import mvas_pkg::*;

    word_t ll_reg, lh_reg, hl_reg, hh_reg;
    prod_t product_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg <= word_t'(a[HALF_BITS-1:0]) * word_t'(b[HALF_BITS-1:0]);
            lh_reg <= word_t'(a[HALF_BITS-1:0]) * word_t'(b[WORD_BITS-1:HALF_BITS]);
            hl_reg <= word_t'(a[WORD_BITS-1:HALF_BITS]) * word_t'(b[HALF_BITS-1:0]);
            hh_reg <= word_t'(a[WORD_BITS-1:HALF_BITS]) * word_t'(b[WORD_BITS-1:HALF_BITS]);
            product_reg <= {hh_reg, ll_reg}
                         + (prod_t'(lh_reg) << HALF_BITS)
                         + (prod_t'(hl_reg) << HALF_BITS);
        end
    end

    assign product = product_reg;

endmodule

// ===== rtl/mvas_rem_step.sv =====
module mvas_rem_step (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  mvas_pkg::word_t     q,
    input  mvas_pkg::stage_t    stage_in,
    output mvas_pkg::stage_t    stage_out
);
    import mvas_pkg::*;

    stage_t stage_reg, stage_next;
    word_t  shifted;

    always_comb
    begin
        stage_next = stage_in;
        // shift in the next product bit; a carry out means the value overflowed past q
        shifted = {stage_in.r[WORD_BITS-2:0], stage_in.p[PROD_BITS-1]};
        if (stage_in.r[WORD_BITS-1] || shifted >= q)
            stage_next.r = shifted - q;
        else
            stage_next.r = shifted;
        stage_next.p = {stage_in.p[PROD_BITS-2:0], 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_reg <= '0;
        else if (en)
            stage_reg <= stage_next;
    end

    assign stage_out = stage_reg;

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import mvas_pkg::*;

    typedef struct {
        word_t value;
        logic  last;
    } element_result_t;

    class result_board;
        word_t           q;
        element_result_t pending[$];
        int              errors;

        function new();
            q = 64'd1024;
            errors = 0;
        endfunction

        function automatic word_t reduce1(word_t v);
            return (v >= q) ? v - q : v;
        endfunction

        function automatic word_t wide_remainder(prod_t p);
            word_t r;
            logic  carry;
            r = '0;
            for (int i = PROD_BITS - 1; i >= 0; i--)
            begin
                carry = r[WORD_BITS-1];
                r = {r[WORD_BITS-2:0], p[i]};
                if (carry || r >= q)
                    r = r - q;
            end
            return r;
        endfunction

        function void note_request(logic [1:0] cmd, word_t a, word_t b, logic last);
            element_result_t e;
            prod_t           p;
            e.last = last;
            e.value = '0;
            if (cmd == CMD_ADD)
                e.value = reduce1(a + b);
            else if (cmd == CMD_SUB)
                e.value = reduce1(a + reduce1(q - b));
            else if (cmd == CMD_MUL)
            begin
                p = prod_t'(a) * prod_t'(b);
                e.value = (q == '0) ? p[WORD_BITS-1:0] : wide_remainder(p);
            end
            pending.push_back(e);
        endfunction

        task check_result(word_t value, logic last);
            element_result_t e;
            if (pending.size() == 0)
            begin
                report_error("result with nothing pending", value, '0);
                return;
            end
            e = pending.pop_front();
            if (value !== e.value)
                report_error("result_value", value, e.value);
            if (last !== e.last)
                report_error("last_out", word_t'(last), word_t'(e.last));
        endtask

        task report_error(string what, word_t got, word_t want);
            $display("mismatch %s: got %h want %h", what, got, want);
            errors++;
        endtask
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        modulus_we = 0;
    word_t       modulus_wdata = '0;
    logic        in_valid = 0;
    logic        in_ready;
    logic [1:0]  command = '0;
    word_t       first_operand = '0;
    word_t       second_operand = '0;
    logic        last_element = 0;
    logic        out_valid;
    logic        out_ready = 0;
    word_t       result_value;
    logic        last_out;
    logic        long_hold = 0;
    result_board board = new();

    modular_vector_add_sub_mul_top u_top (
        .clk(clk), .rst_n(rst_n), .modulus_we(modulus_we), .modulus_wdata(modulus_wdata),
        .in_valid(in_valid), .in_ready(in_ready), .command(command),
        .first_operand(first_operand), .second_operand(second_operand),
        .last_element(last_element), .out_valid(out_valid), .out_ready(out_ready),
        .result_value(result_value), .last_out(last_out)
    );

    always #1 clk = ~clk;

    function automatic int gap_length();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    endfunction

    function automatic word_t rand_word();
        return {$urandom(), $urandom()};
    endfunction

    // operand mostly below q, sometimes anything
    function automatic word_t rand_operand(word_t q);
        word_t v;
        v = rand_word();
        if ($urandom_range(0, 4) != 0 && q > 1)
            v = v % q;
        return v;
    endfunction

    // leave valid high after the accept; a gap before the next request or a drain drops it
    task automatic send_request(logic [1:0] cmd, word_t a, word_t b, logic last,
                                bit allow_gap);
        int gap;
        gap = allow_gap ? gap_length() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        first_operand <= a;
        second_operand <= b;
        last_element <= last;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_request(cmd, a, b, last);
    endtask

    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic write_modulus(word_t q);
        drain_pipeline();
        modulus_we <= 1'b1;
        modulus_wdata <= q;
        @(posedge clk);
        modulus_we <= 1'b0;
        board.q = q;
    endtask

    task automatic random_phase(int count, bit pausy);
        logic [1:0] cmd;
        for (int i = 0; i < count; i++)
        begin
            cmd = $urandom_range(0, 15) == 0 ? CMD_UNUSED : 2'($urandom_range(0, 2));
            send_request(cmd, rand_operand(board.q), rand_operand(board.q),
                         $urandom_range(0, 7) == 0, pausy && (i % 50 >= 25));
        end
    endtask

    // receiver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                board.check_result(result_value, last_out);
            out_ready <= long_hold ? 1'b0 : ($urandom_range(0, 9) != 0);
        end
    end

    initial
    begin
        word_t top;
        top = '1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed at reset modulus
        send_request(CMD_ADD, 64'd1023, 64'd1023, 1'b0, 1'b0);
        send_request(CMD_ADD, 64'd0, 64'd0, 1'b1, 1'b0);
        send_request(CMD_SUB, 64'd0, 64'd1023, 1'b0, 1'b0);
        send_request(CMD_SUB, 64'd5, 64'd0, 1'b0, 1'b0);
        send_request(CMD_MUL, top, top, 1'b1, 1'b0);
        send_request(CMD_UNUSED, top, top, 1'b1, 1'b0);
        send_request(CMD_ADD, top, top, 1'b0, 1'b0);
        send_request(CMD_SUB, top, top, 1'b0, 1'b0);
        write_modulus(top);
        send_request(CMD_ADD, top - 1, top - 1, 1'b1, 1'b0);
        send_request(CMD_SUB, 64'd0, top - 1, 1'b0, 1'b0);
        send_request(CMD_MUL, top - 1, top - 1, 1'b0, 1'b0);
        send_request(CMD_MUL, top, top, 1'b1, 1'b0);
        write_modulus(64'd0);
        send_request(CMD_ADD, top, 64'd1, 1'b0, 1'b0);
        send_request(CMD_SUB, 64'd3, 64'd7, 1'b0, 1'b0);
        send_request(CMD_MUL, top, top, 1'b1, 1'b0);
        write_modulus(64'd1);
        send_request(CMD_ADD, 64'd1, 64'd1, 1'b0, 1'b0);
        send_request(CMD_SUB, 64'd0, 64'd1, 1'b0, 1'b0);
        send_request(CMD_MUL, top, 64'd3, 1'b1, 1'b0);
        write_modulus(64'd2);
        send_request(CMD_MUL, top, top, 1'b0, 1'b0);
        send_request(CMD_SUB, 64'd1, 64'd1, 1'b1, 1'b0);
        // long receiver stall while the sender keeps pushing
        write_modulus(rand_word());
        fork
            begin
                long_hold <= 1'b1;
                repeat (400) @(posedge clk);
                long_hold <= 1'b0;
            end
            random_phase(200, 1'b0);
        join
        write_modulus(64'h8000_0000_0000_0001);
        random_phase(250, 1'b1);
        write_modulus({32'h0, $urandom()} | 64'd2);
        random_phase(250, 1'b1);
        write_modulus(top - 64'd58);
        random_phase(250, 1'b1);
        write_modulus(64'd1024);
        random_phase(180, 1'b1);
        drain_pipeline();
        if (board.errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("tb_top: errors");
        $finish;
    end
endmodule
